[rtl/ped_pkg.sv]
// Shared types, codes and constants for the pairwise Euclidean distance block.
package ped_pkg;

    // Default geometry of the descriptor store
    localparam int PED_MAX_VECTORS  = 64;
    localparam int PED_MAX_LENGTH   = 1024;
    localparam int PED_ELEMENT_BITS = 16;

    // Fixed field widths
    localparam int ROW_W      = 6;
    localparam int IDX_W      = 10;
    localparam int VAL_W      = 16;
    localparam int DIST_W     = 21;
    localparam int VCOUNT_W   = 7;
    localparam int VLEN_W     = 11;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // Register reset values
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;
    localparam logic [VLEN_W-1:0]   VLEN_RESET   = 11'd512;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_COUNT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = 4'd1;

    // Request function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Response status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [ROW_W-1:0]        row_a;
        logic [ROW_W-1:0]        row_b;
        logic [IDX_W-1:0]        element_index;
        logic signed [VAL_W-1:0] element_value;
    } t_req;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              status;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STREAM,
        ST_DRAIN,
        ST_ROOT,
        ST_FINISH
    } t_state;

endpackage

[rtl/pairwise_euclidean_distance.sv]
// Top level: descriptor store with pairwise Euclidean distance queries.
//
//  channel   direction  handshake                   payload
//  request   in         i_req_valid / o_req_ready   i_req  (t_req)
//  response  out        o_rsp_valid / i_rsp_ready   o_rsp  (t_rsp)
//  config    in         i_cfg_we                    i_cfg_idx, i_cfg_data
//
//  A write request is stored when it is taken; requests are taken only while no query runs.
//  A query streams L = min(vector_length, MAX_LENGTH) element pairs, one pair a cycle,
//  through a three-stage difference/square/accumulate pipe, loads the sum into the root
//  and runs R = 22 root steps at the defaults; an empty length skips the pipe and
//  a row out of range goes straight to the finish state.
//  A result waits in the output register while the next request is taken; a query stalls
//  in its last cycle only while an earlier result is unread. Reset spares the store.
module pairwise_euclidean_distance #(
    parameter int MAX_VECTORS  = ped_pkg::PED_MAX_VECTORS,
    parameter int MAX_LENGTH   = ped_pkg::PED_MAX_LENGTH,
    parameter int ELEMENT_BITS = ped_pkg::PED_ELEMENT_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_req_valid,
    output logic                                 o_req_ready,
    input  ped_pkg::t_req                        i_req,
    output logic                                 o_rsp_valid,
    input  logic                                 i_rsp_ready,
    output ped_pkg::t_rsp                        o_rsp,
    input  logic                                 i_cfg_we,
    input  logic [ped_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [ped_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import ped_pkg::*;

    localparam int EB      = ELEMENT_BITS;
    localparam int DEPTH   = MAX_VECTORS * MAX_LENGTH;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int LEN_W   = $clog2(MAX_LENGTH + 1);
    localparam int SUM_RAW = 2 * EB + $clog2(MAX_LENGTH + 1);
    localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
    localparam int RT_W    = (SUM_W + 1) / 2;
    localparam int STEP_W  = $clog2(RT_W);

    localparam logic signed [32:0] ELEM_HI = (33'sd1 <<< (EB - 1)) - 33'sd1;
    localparam logic signed [32:0] ELEM_LO = -ELEM_HI - 33'sd1;

    // Registers
    t_state                 r_state, n_state;
    logic [VCOUNT_W-1:0]    r_vector_count;
    logic [VLEN_W-1:0]      r_vector_length;
    logic [ROW_W-1:0]       r_row_a, r_row_b;
    logic                   r_err;
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       r_k;
    logic [EB-1:0]          r_mem [DEPTH];
    logic [EB-1:0]          r_rdata_a, r_rdata_b;
    logic                   r_rd_vld, r_mag_vld, r_sq_vld;
    logic [EB-1:0]          r_mag;
    logic [2*EB-1:0]        r_sq;
    logic [SUM_W-1:0]       r_sum;
    logic [2*RT_W-1:0]      r_rad;
    logic [RT_W-1:0]        r_rem;
    logic [RT_W-1:0]        r_root;
    logic [STEP_W-1:0]      r_step;
    logic                   r_rsp_valid;
    t_rsp                   r_rsp;

    // Control and datapath signals
    logic                   req_acc;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [EB-1:0]          wr_data;
    logic signed [32:0]     wr_clamp;
    logic                   q_err;
    logic [LEN_W-1:0]       q_len;
    logic [ADDR_W-1:0]      rd_addr_a, rd_addr_b;
    logic                   issue;
    logic                   last_issue;
    logic                   pipe_empty;
    logic                   root_load;
    logic                   root_last;
    logic                   rsp_load;
    logic signed [EB:0]     diff;
    logic [EB:0]            diff_abs;
    logic [SUM_W:0]         sum_ext;
    logic [RT_W+1:0]        rem_shift;
    logic [RT_W+1:0]        trial;
    logic                   take_bit;
    logic [RT_W+1:0]        rem_sub;
    logic [DIST_W-1:0]      dist_sat;

    assign req_acc = i_req_valid && o_req_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vector_count  <= VCOUNT_RESET;
            r_vector_length <= VLEN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_VECTOR_COUNT) begin
                r_vector_count <= i_cfg_data[VCOUNT_W-1:0];
            end else if (i_cfg_idx == CFG_VECTOR_LENGTH) begin
                r_vector_length <= i_cfg_data[VLEN_W-1:0];
            end
        end
    end

    // Decode a write request: saturate the element and drop writes outside the store
    always_comb begin
        wr_clamp = 33'(i_req.element_value);
        if (wr_clamp > ELEM_HI) begin
            wr_clamp = ELEM_HI;
        end else if (wr_clamp < ELEM_LO) begin
            wr_clamp = ELEM_LO;
        end
        wr_data = wr_clamp[EB-1:0];
        wr_addr = ADDR_W'(ADDR_W'(i_req.row_a) * ADDR_W'(MAX_LENGTH))
                + ADDR_W'(i_req.element_index);
        wr_en   = req_acc && (i_req.func == FUNC_WRITE)
               && (int'(i_req.row_a) < MAX_VECTORS)
               && (int'(i_req.element_index) < MAX_LENGTH);
    end

    // Decode a query request: row range check and clipped length
    always_comb begin
        q_err = (i_req.row_a >= ROW_W'(r_vector_count) && r_vector_count[VCOUNT_W-1] == 1'b0)
             || (i_req.row_b >= ROW_W'(r_vector_count) && r_vector_count[VCOUNT_W-1] == 1'b0)
             || (int'(i_req.row_a) >= MAX_VECTORS)
             || (int'(i_req.row_b) >= MAX_VECTORS);
        if (int'(r_vector_length) > MAX_LENGTH) begin
            q_len = LEN_W'(MAX_LENGTH);
        end else begin
            q_len = LEN_W'(r_vector_length);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (req_acc && i_req.func == FUNC_QUERY) begin
                    if (q_err) begin
                        n_state = ST_FINISH;
                    end else if (q_len == '0) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_state = ST_STREAM;
                    end
                end
            end
            ST_STREAM: begin
                if (last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (root_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (rsp_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_req_ready = 1'b0;
        issue       = 1'b0;
        root_load   = 1'b0;
        rsp_load    = 1'b0;
        case (r_state)
            ST_IDLE:   o_req_ready = 1'b1;
            ST_STREAM: issue       = 1'b1;
            ST_DRAIN:  root_load   = pipe_empty;
            ST_ROOT:   root_load   = 1'b0;
            ST_FINISH: rsp_load    = !r_rsp_valid || i_rsp_ready;
            default:   o_req_ready = 1'b0;
        endcase
    end

    assign last_issue = (r_k + LEN_W'(1)) == r_len;
    assign pipe_empty = !r_rd_vld && !r_mag_vld && !r_sq_vld;
    assign root_last  = (r_step == STEP_W'(RT_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Latch query operands
    always_ff @(posedge i_clk) begin
        if (req_acc && i_req.func == FUNC_QUERY) begin
            r_row_a <= i_req.row_a;
            r_row_b <= i_req.row_b;
            r_err   <= q_err;
            r_len   <= q_len;
        end
    end

    // Element counter
    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_k <= '0;
        end else if (issue) begin
            r_k <= r_k + LEN_W'(1);
        end
    end

    assign rd_addr_a = ADDR_W'(ADDR_W'(r_row_a) * ADDR_W'(MAX_LENGTH)) + ADDR_W'(r_k);
    assign rd_addr_b = ADDR_W'(ADDR_W'(r_row_b) * ADDR_W'(MAX_LENGTH)) + ADDR_W'(r_k);

    // Descriptor store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata_a <= r_mem[rd_addr_a];
            r_rdata_b <= r_mem[rd_addr_b];
        end
    end

    // Pipe valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_mag_vld <= 1'b0;
            r_sq_vld  <= 1'b0;
        end else begin
            r_rd_vld  <= issue;
            r_mag_vld <= r_rd_vld;
            r_sq_vld  <= r_mag_vld;
        end
    end

    // Difference magnitude, square, saturating accumulate
    always_comb begin
        diff     = (EB+1)'(signed'(r_rdata_a)) - (EB+1)'(signed'(r_rdata_b));
        diff_abs = diff[EB] ? (EB+1)'(-diff) : (EB+1)'(diff);
        sum_ext  = {1'b0, r_sum} + (SUM_W+1)'(r_sq);
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_mag <= diff_abs[EB-1:0];
        end
        if (r_mag_vld) begin
            r_sq <= r_mag * r_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_acc) begin
            r_sum <= '0;
        end else if (r_sq_vld) begin
            r_sum <= sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
        end
    end

    // Square root: one result bit per step
    always_comb begin
        rem_shift = {r_rem, r_rad[2*RT_W-1 -: 2]};
        trial     = {r_root, 2'b01};
        take_bit  = rem_shift >= trial;
        rem_sub   = take_bit ? (rem_shift - trial) : rem_shift;
    end

    always_ff @(posedge i_clk) begin
        if (root_load) begin
            r_rad  <= (2*RT_W)'(r_sum);
            r_rem  <= '0;
            r_root <= '0;
            r_step <= '0;
        end else if (r_state == ST_ROOT) begin
            r_rad  <= r_rad << 2;
            r_rem  <= rem_sub[RT_W-1:0];
            r_root <= {r_root[RT_W-2:0], take_bit};
            r_step <= r_step + STEP_W'(1);
        end
    end

    // Clamp the root to the distance range
    always_comb begin
        if (64'(r_root) > 64'(DIST_MAX)) begin
            dist_sat = DIST_MAX;
        end else begin
            dist_sat = DIST_W'(r_root);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (rsp_load) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rsp_load) begin
            r_rsp.distance <= r_err ? '0 : dist_sat;
            r_rsp.status   <= r_err ? STATUS_RANGE : STATUS_OK;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

`ifndef NO_ASSERTIONS
    // A range error always reports zero distance
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status == STATUS_RANGE) |-> (o_rsp.distance == '0))
        else $error("range error response with nonzero distance");

    // The element counter stays below the clipped length while streaming
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STREAM) |-> (r_k < r_len))
        else $error("element counter past vector length");

    // Pipe data in flight only while a query streams or drains
    a_pipe_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_vld || r_mag_vld || r_sq_vld) |-> (r_state == ST_STREAM || r_state == ST_DRAIN))
        else $error("pipe active outside a query");

    // A new response comes only out of the finish state
    a_rsp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(r_state == ST_FINISH))
        else $error("response raised outside finish state");
`endif

endmodule
